>>> src/slr_pkg.sv
// Shared types and constants for the sliding-window log rate limiter.
// No dependencies; imported by slr_cell and sliding_log_rate_limiter.
package slr_pkg;

    localparam int STAMP_W       = 32;
    localparam int WIN_W         = 16;
    localparam int LIM_W         = 7;
    localparam int WAIT_W        = 16;
    localparam int CNT_OUT_W     = 7;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int OUT_DATA_W    = 32;
    localparam int LOG_DEPTH_DEF = 64;

    localparam logic [WIN_W-1:0] WINDOW_RESET  = 16'd60;
    localparam logic [LIM_W-1:0] MAX_REQ_RESET = 7'd30;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS  = 8'd1;

    localparam logic OP_CHECK   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // per-cell control: shift towards the head, or load the current time
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

>>> src/slr_cell.sv
// One cell of the time-stamp chain: holds a single logged time.
// Depends on slr_pkg (t_cell_ctrl, STAMP_W).
module slr_cell (
    input  logic                   i_clk,
    input  slr_pkg::t_cell_ctrl    i_ctrl,
    input  logic [slr_pkg::STAMP_W-1:0] i_next,   // stamp of the younger neighbour
    input  logic [slr_pkg::STAMP_W-1:0] i_now,
    output logic [slr_pkg::STAMP_W-1:0] o_stamp
);
    import slr_pkg::*;

    logic [STAMP_W-1:0] r_stamp;
    logic [STAMP_W-1:0] n_stamp;

    always_comb begin
        n_stamp = r_stamp;
        if (i_ctrl.load) begin
            n_stamp = i_now;
        end else if (i_ctrl.shift) begin
            n_stamp = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
    end

    assign o_stamp = r_stamp;

endmodule

>>> src/sliding_log_rate_limiter.sv
// Sliding-window log rate limiter, top level.
// Depends on slr_pkg and slr_cell.
//
// Usage
//   Input stream (s_axis_*): one transaction per item. tdata carries now_time,
//   tuser carries op (0 check only, 1 request: check and log when allowed).
//   Output stream (m_axis_*): one transaction per item with allowed,
//   wait_ticks, recorded and window_count packed into tdata.
//   Config channel (i_cfg_*): index 0 window_length, index 1 max_requests;
//   other indices are ignored. Ready whenever out of reset; write only while idle.
// Timing
//   Logged times sit in a row of cells, oldest in cell 0. Pruning shifts the
//   row one cell per cycle, once for each entry that ages out on an item
//   (0 to LOG_DEPTH), and the decision step follows once no aged entry is
//   left. A new item is taken only after the last one has left the decision step.
// Reset
//   Synchronous, active low: log empty, registers back to 60 and 30. Both
//   input-side readies stay low while reset is held.
//   No clearing pass; cells hold nothing meaningful until written.
// Back-pressure
//   The result waits in an output register; the next item is taken while it
//   waits, and processing holds at the decision step until the register frees.
module sliding_log_rate_limiter #(
    parameter int LOG_DEPTH = slr_pkg::LOG_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [slr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [slr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [slr_pkg::STAMP_W-1:0]       s_axis_tdata,  // [31:0] now_time
    input  logic                              s_axis_tuser,  // [0] op
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] allowed, [16:1] wait_ticks, [17] recorded, [24:18] window_count,
    // [31:25] zero
    output logic [slr_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import slr_pkg::*;

    localparam int CW = $clog2(LOG_DEPTH + 1);        // width of the fill count
    localparam int LW = (CW > LIM_W) ? CW : LIM_W;    // width for limit compare
    localparam int DW = STAMP_W + 2;                  // signed headroom for ageing sum
    localparam int PAD_W = OUT_DATA_W - (1 + WAIT_W + 1 + CNT_OUT_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRUNE,
        S_DECIDE
    } t_state;

    t_state               r_state;
    logic [WIN_W-1:0]     r_window;
    logic [LIM_W-1:0]     r_max_req;
    logic [CW-1:0]        r_count;
    logic                 r_op;
    logic [STAMP_W-1:0]   r_now;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [STAMP_W-1:0]   w_stamp [LOG_DEPTH];
    t_cell_ctrl           w_ctrl  [LOG_DEPTH];

    logic [DW-1:0]        w_diff;
    logic                 w_expired;
    logic [LW-1:0]        w_limit;
    logic                 w_allowed;
    logic                 w_record;
    logic [WAIT_W-1:0]    w_wait;
    logic [CW-1:0]        w_count_after;
    logic                 w_out_free;
    logic                 w_do_shift;
    logic                 w_do_load;

    // ---------------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------------
    for (genvar k = 0; k < LOG_DEPTH; k++) begin : g_cell
        logic [STAMP_W-1:0] w_next;
        if (k == LOG_DEPTH - 1) begin : g_tail
            assign w_next = w_stamp[k];
        end else begin : g_body
            assign w_next = w_stamp[k+1];
        end

        assign w_ctrl[k].shift = w_do_shift;
        assign w_ctrl[k].load  = w_do_load && (r_count == CW'(k));

        slr_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl[k]),
            .i_next  (w_next),
            .i_now   (r_now),
            .o_stamp (w_stamp[k])
        );
    end

    // ---------------------------------------------------------------------
    // Ageing and decision datapath
    // ---------------------------------------------------------------------
    // oldest + window - now; negative means the oldest entry has aged out
    assign w_diff    = {2'b00, w_stamp[0]} + {{(DW-WIN_W){1'b0}}, r_window}
                     - {2'b00, r_now};
    assign w_expired = w_diff[DW-1];

    always_comb begin
        if (r_max_req == '0) begin
            w_limit = LW'(1);
        end else if (LW'(r_max_req) > LW'(LOG_DEPTH)) begin
            w_limit = LW'(LOG_DEPTH);
        end else begin
            w_limit = LW'(r_max_req);
        end
    end

    assign w_allowed = LW'(r_count) < w_limit;
    assign w_record  = w_allowed && (r_op == OP_REQUEST) && (r_count < CW'(LOG_DEPTH));
    assign w_count_after = w_record ? r_count + CW'(1) : r_count;

    // refused wait: at least one tick, saturating
    always_comb begin
        if (w_diff[DW-1] || (w_diff == '0)) begin
            w_wait = WAIT_W'(1);
        end else if (w_diff[DW-2:WAIT_W] != '0) begin
            w_wait = '1;
        end else begin
            w_wait = w_diff[WAIT_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_do_shift = (r_state == S_PRUNE) && (r_count != '0) && w_expired;
    assign w_do_load  = (r_state == S_DECIDE) && w_out_free && w_record;

    // ---------------------------------------------------------------------
    // Control and registered outputs
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WINDOW_RESET;
            r_max_req   <= MAX_REQ_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_WINDOW_LENGTH: r_window  <= i_cfg_data[WIN_W-1:0];
                    REG_MAX_REQUESTS:  r_max_req <= i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end

            // a new result replaces the one leaving in the same cycle
            if (r_state == S_DECIDE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_PRUNE;
                    end
                end
                S_PRUNE: begin
                    // one aged entry leaves per cycle
                    if (w_do_shift) begin
                        r_count <= r_count - CW'(1);
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (w_out_free) begin
                        r_count     <= w_count_after;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item and result payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_now <= s_axis_tdata;
            r_op  <= s_axis_tuser;
        end
        if (r_state == S_DECIDE && w_out_free) begin
            r_out_data <= {{PAD_W{1'b0}},
                           CNT_OUT_W'(w_count_after),
                           w_record,
                           (w_allowed ? {WAIT_W{1'b0}} : w_wait),
                           w_allowed};
        end
    end

    assign o_cfg_ready   = i_rst_n;
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
